// File: hdl/lss_pkg.sv
// shared constants, command and status types and arithmetic helpers of the solver
package lss_pkg;

    localparam int MAX_N       = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int W           = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int FRAC        = 16;
    localparam int COLS        = MAX_N + 1;
    localparam int DEPTH       = MAX_N * COLS;
    localparam int AW          = $clog2(DEPTH);
    localparam int IW          = $clog2(MAX_N + 1);
    localparam int SW          = $clog2(MAX_N);
    localparam int SIZE_W      = 4;
    localparam int OUT_IDX_W   = 3;

    // store write data select
    localparam logic [1:0] WSEL_IN   = 2'd0;
    localparam logic [1:0] WSEL_RD   = 2'd1;
    localparam logic [1:0] WSEL_T    = 2'd2;
    localparam logic [1:0] WSEL_DIFF = 2'd3;

    typedef struct packed {
        logic            mem_we;
        logic [AW-1:0]   waddr;
        logic [1:0]      wsel;
        logic [AW-1:0]   raddr;
        logic            lat_piv;
        logic            lat_t;
        logic            lat_a;
        logic            lat_b;
        logic            mul_en;
        logic            mul_sel;
        logic            div_start;
        logic            div_sel;
        logic            lat_m;
        logic            acc_load;
        logic            acc_sub;
        logic            sol_we;
        logic [IW-1:0]   sol_idx;
        logic            out_load;
        logic            out_last;
        logic            out_sing;
    } lss_cmd_t;

    typedef struct packed {
        logic rd_zero;
        logic div_done;
    } lss_sts_t;

    function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        logic [AW+IW:0] t;
        t = (AW+IW+1)'(r) * (AW+IW+1)'(COLS) + (AW+IW+1)'(c);
        return t[AW-1:0];
    endfunction

    // product scaled down by 2^FRAC, truncated toward zero, saturated
    function automatic logic signed [W-1:0] fx_scale(input logic signed [2*W-1:0] p);
        logic signed [2*W-1:0] adj;
        logic signed [2*W-1:0] sh;
        logic signed [2*W-1:0] hi;
        logic signed [2*W-1:0] lo;
        hi  = (2*W)'({1'b0, {(W-1){1'b1}}});
        lo  = -hi - (2*W)'(1);
        adj = p + ((p < 0) ? (2*W)'((1 << FRAC) - 1) : '0);
        sh  = adj >>> FRAC;
        if (sh > hi) return {1'b0, {(W-1){1'b1}}};
        if (sh < lo) return {1'b1, {(W-1){1'b0}}};
        return sh[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] d;
        d = {a[W-1], a} - {b[W-1], b};
        if (d[W] != d[W-1]) return d[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        return d[W-1:0];
    endfunction

endpackage

// File: hdl/lss_div.sv
// radix-2 restoring divider for the fixed-point quotient, one bit per cycle while busy
module lss_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [lss_pkg::W-1:0] a,
    input  logic signed [lss_pkg::W-1:0] b,
    output logic                        done,
    output logic signed [lss_pkg::W-1:0] q
);
    import lss_pkg::*;

    localparam int DW = W + FRAC;
    localparam int CW = $clog2(DW);

    logic          busy_reg, busy_next;
    logic          fin_reg, fin_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic          neg_reg, neg_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W:0]    rem_sh;
    logic [W-1:0]  abs_a;
    logic [W-1:0]  abs_b;

    always_comb
    begin
        abs_a     = a[W-1] ? (~a + W'(1)) : a;
        abs_b     = b[W-1] ? (~b + W'(1)) : b;
        rem_sh    = {rem_reg[W-1:0], dvd_reg[DW-1]};
        busy_next = busy_reg;
        fin_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (start && !busy_reg && !fin_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = {abs_a, {FRAC{1'b0}}};
            quo_next  = '0;
            rem_next  = '0;
            dsr_next  = abs_b;
            neg_next  = a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = rem_sh - {1'b0, dsr_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
        else if (fin_reg)
        begin
            done_next = 1'b1;
            if (neg_reg)
            begin
                if (quo_reg > DW'({1'b1, {(W-1){1'b0}}}))
                    q_next = {1'b1, {(W-1){1'b0}}};
                else
                    q_next = ~quo_reg[W-1:0] + W'(1);
            end
            else
            begin
                if (quo_reg > DW'({1'b0, {(W-1){1'b1}}}))
                    q_next = {1'b0, {(W-1){1'b1}}};
                else
                    q_next = quo_reg[W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

// File: hdl/lss_dp.sv
// solver datapath: matrix store, multiplier, divider, accumulator and output registers
module lss_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lss_pkg::lss_cmd_t             cmd,
    output lss_pkg::lss_sts_t             sts,
    input  logic signed [lss_pkg::W-1:0]  value,
    output logic signed [lss_pkg::W-1:0]  solution,
    output logic [lss_pkg::OUT_IDX_W-1:0] index,
    output logic                          singular,
    output logic                          last
);
    import lss_pkg::*;

    logic signed [W-1:0]   mem [DEPTH];
    logic signed [W-1:0]   rdata_reg;
    logic signed [W-1:0]   sol_reg [MAX_N];
    logic signed [W-1:0]   piv_reg, t_reg, a_reg, b_reg, m_reg, acc_reg;
    logic signed [2*W-1:0] prod_reg;
    logic signed [W-1:0]   wdata;
    logic signed [W-1:0]   mul_b;
    logic signed [W-1:0]   fx_prod;
    logic signed [W-1:0]   div_a, div_b, div_q;
    logic                  div_done;
    logic signed [W-1:0]   sol_rd;
    logic signed [W-1:0]   sol_reg_out;
    logic [OUT_IDX_W-1:0]  idx_reg;
    logic                  sing_reg, last_reg;

    lss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .a     (div_a),
        .b     (div_b),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        sol_rd  = sol_reg[cmd.sol_idx[SW-1:0]];
        fx_prod = fx_scale(prod_reg);
        mul_b   = cmd.mul_sel ? sol_rd : m_reg;
        div_a   = cmd.div_sel ? acc_reg : rdata_reg;
        div_b   = cmd.div_sel ? rdata_reg : piv_reg;
        unique case (cmd.wsel)
            WSEL_IN:   wdata = value;
            WSEL_RD:   wdata = rdata_reg;
            WSEL_T:    wdata = t_reg;
            WSEL_DIFF: wdata = sat_sub(b_reg, fx_prod);
            default:   wdata = value;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[cmd.waddr] <= wdata;
        rdata_reg <= mem[cmd.raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lat_piv)  piv_reg  <= rdata_reg;
        if (cmd.lat_t)    t_reg    <= rdata_reg;
        if (cmd.lat_a)    a_reg    <= rdata_reg;
        if (cmd.lat_b)    b_reg    <= rdata_reg;
        if (cmd.mul_en)   prod_reg <= a_reg * mul_b;
        if (cmd.lat_m && div_done) m_reg <= div_q;
        if (cmd.acc_load) acc_reg  <= rdata_reg;
        else if (cmd.acc_sub) acc_reg <= sat_sub(acc_reg, fx_prod);
        if (cmd.sol_we && div_done) sol_reg[cmd.sol_idx[SW-1:0]] <= div_q;
        if (cmd.out_load)
        begin
            sol_reg_out <= cmd.out_sing ? '0 : sol_rd;
            idx_reg     <= cmd.sol_idx[OUT_IDX_W-1:0];
            sing_reg    <= cmd.out_sing;
            last_reg    <= cmd.out_last;
        end
    end

    assign sts.rd_zero  = (rdata_reg == '0);
    assign sts.div_done = div_done;
    assign solution     = sol_reg_out;
    assign index        = idx_reg;
    assign singular     = sing_reg;
    assign last         = last_reg;

endmodule

// File: hdl/lss_ctrl.sv
// solver sequencer: load, forward elimination, back-substitution and result output
module lss_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [lss_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    output lss_pkg::lss_cmd_t          cmd,
    input  lss_pkg::lss_sts_t          sts
);
    import lss_pkg::*;

    localparam logic [4:0] S_LOAD     = 5'd0;
    localparam logic [4:0] S_PIV_RD   = 5'd1;
    localparam logic [4:0] S_PIV_CHK  = 5'd2;
    localparam logic [4:0] S_SRCH_RD  = 5'd3;
    localparam logic [4:0] S_SRCH_CHK = 5'd4;
    localparam logic [4:0] S_SWP_A    = 5'd5;
    localparam logic [4:0] S_SWP_B    = 5'd6;
    localparam logic [4:0] S_SWP_C    = 5'd7;
    localparam logic [4:0] S_SWP_D    = 5'd8;
    localparam logic [4:0] S_ELIM_J   = 5'd9;
    localparam logic [4:0] S_ELIM_CHK = 5'd10;
    localparam logic [4:0] S_ELIM_DIV = 5'd11;
    localparam logic [4:0] S_ROW_A    = 5'd12;
    localparam logic [4:0] S_ROW_B    = 5'd13;
    localparam logic [4:0] S_ROW_C    = 5'd14;
    localparam logic [4:0] S_ROW_D    = 5'd15;
    localparam logic [4:0] S_BS_I     = 5'd16;
    localparam logic [4:0] S_BS_ACC   = 5'd17;
    localparam logic [4:0] S_BS_J     = 5'd18;
    localparam logic [4:0] S_BS_M     = 5'd19;
    localparam logic [4:0] S_BS_P     = 5'd20;
    localparam logic [4:0] S_BS_SUB   = 5'd21;
    localparam logic [4:0] S_BS_DST   = 5'd22;
    localparam logic [4:0] S_BS_DIV   = 5'd23;
    localparam logic [4:0] S_EMIT_LD  = 5'd24;
    localparam logic [4:0] S_EMIT_W   = 5'd25;

    logic [4:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [IW-1:0]     i_reg, i_next;
    logic [IW-1:0]     j_reg, j_next;
    logic [IW-1:0]     k_reg, k_next;
    logic [IW-1:0]     r_reg, r_next;
    logic              sing_reg, sing_next;
    logic [IW-1:0]     n_act;
    logic [IW-1:0]     n_m1;

    always_comb
    begin
        if (size_reg == '0)
            n_act = IW'(1);
        else if (size_reg > SIZE_W'(MAX_N))
            n_act = IW'(MAX_N);
        else
            n_act = IW'(size_reg);
        n_m1 = n_act - IW'(1);
    end

    always_comb
    begin
        state_next = state_reg;
        size_next  = size_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        r_next     = r_reg;
        sing_next  = sing_reg;
        cmd        = '0;
        cmd.out_sing = sing_reg;

        if (cfg_write)
        begin
            size_next = cfg_data;
            i_next    = '0;
            k_next    = '0;
        end

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid && !cfg_write)
                begin
                    cmd.mem_we = 1'b1;
                    cmd.waddr  = cell_addr(i_reg, k_reg);
                    cmd.wsel   = WSEL_IN;
                    if (k_reg == n_act)
                    begin
                        k_next = '0;
                        if (i_reg == n_m1)
                        begin
                            i_next     = '0;
                            sing_next  = 1'b0;
                            state_next = S_PIV_RD;
                        end
                        else
                            i_next = i_reg + IW'(1);
                    end
                    else
                        k_next = k_reg + IW'(1);
                end
            end
            S_PIV_RD:
            begin
                cmd.raddr  = cell_addr(i_reg, i_reg);
                state_next = S_PIV_CHK;
            end
            S_PIV_CHK:
            begin
                cmd.lat_piv = 1'b1;
                if (sts.rd_zero)
                begin
                    r_next     = i_reg + IW'(1);
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    j_next     = i_reg + IW'(1);
                    state_next = S_ELIM_J;
                end
            end
            S_SRCH_RD:
            begin
                if (r_reg == n_act)
                begin
                    sing_next  = 1'b1;
                    k_next     = '0;
                    state_next = S_EMIT_LD;
                end
                else
                begin
                    cmd.raddr  = cell_addr(r_reg, i_reg);
                    state_next = S_SRCH_CHK;
                end
            end
            S_SRCH_CHK:
            begin
                if (sts.rd_zero)
                begin
                    r_next     = r_reg + IW'(1);
                    state_next = S_SRCH_RD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = S_SWP_A;
                end
            end
            S_SWP_A:
            begin
                cmd.raddr  = cell_addr(i_reg, k_reg);
                state_next = S_SWP_B;
            end
            S_SWP_B:
            begin
                cmd.lat_t  = 1'b1;
                cmd.raddr  = cell_addr(r_reg, k_reg);
                state_next = S_SWP_C;
            end
            S_SWP_C:
            begin
                cmd.mem_we = 1'b1;
                cmd.waddr  = cell_addr(i_reg, k_reg);
                cmd.wsel   = WSEL_RD;
                state_next = S_SWP_D;
            end
            S_SWP_D:
            begin
                cmd.mem_we = 1'b1;
                cmd.waddr  = cell_addr(r_reg, k_reg);
                cmd.wsel   = WSEL_T;
                if (k_reg == n_act)
                    state_next = S_PIV_RD;
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_SWP_A;
                end
            end
            S_ELIM_J:
            begin
                if (j_reg == n_act)
                begin
                    if (i_reg == n_m1)
                        state_next = S_BS_I;
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        state_next = S_PIV_RD;
                    end
                end
                else
                begin
                    cmd.raddr  = cell_addr(j_reg, i_reg);
                    state_next = S_ELIM_CHK;
                end
            end
            S_ELIM_CHK:
            begin
                if (sts.rd_zero)
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_ELIM_J;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_ELIM_DIV;
                end
            end
            S_ELIM_DIV:
            begin
                cmd.lat_m = 1'b1;
                if (sts.div_done)
                begin
                    k_next     = '0;
                    state_next = S_ROW_A;
                end
            end
            S_ROW_A:
            begin
                cmd.raddr  = cell_addr(i_reg, k_reg);
                state_next = S_ROW_B;
            end
            S_ROW_B:
            begin
                cmd.lat_a  = 1'b1;
                cmd.raddr  = cell_addr(j_reg, k_reg);
                state_next = S_ROW_C;
            end
            S_ROW_C:
            begin
                cmd.lat_b  = 1'b1;
                cmd.mul_en = 1'b1;
                state_next = S_ROW_D;
            end
            S_ROW_D:
            begin
                cmd.mem_we = 1'b1;
                cmd.waddr  = cell_addr(j_reg, k_reg);
                cmd.wsel   = WSEL_DIFF;
                if (k_reg == n_act)
                begin
                    j_next     = j_reg + IW'(1);
                    state_next = S_ELIM_J;
                end
                else
                begin
                    k_next     = k_reg + IW'(1);
                    state_next = S_ROW_A;
                end
            end
            S_BS_I:
            begin
                cmd.raddr  = cell_addr(i_reg, n_act);
                state_next = S_BS_ACC;
            end
            S_BS_ACC:
            begin
                cmd.acc_load = 1'b1;
                j_next       = i_reg + IW'(1);
                state_next   = S_BS_J;
            end
            S_BS_J:
            begin
                if (j_reg == n_act)
                begin
                    cmd.raddr  = cell_addr(i_reg, i_reg);
                    state_next = S_BS_DST;
                end
                else
                begin
                    cmd.raddr  = cell_addr(i_reg, j_reg);
                    state_next = S_BS_M;
                end
            end
            S_BS_M:
            begin
                cmd.lat_a  = 1'b1;
                state_next = S_BS_P;
            end
            S_BS_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = 1'b1;
                cmd.sol_idx = j_reg;
                state_next  = S_BS_SUB;
            end
            S_BS_SUB:
            begin
                cmd.acc_sub = 1'b1;
                j_next      = j_reg + IW'(1);
                state_next  = S_BS_J;
            end
            S_BS_DST:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = 1'b1;
                state_next    = S_BS_DIV;
            end
            S_BS_DIV:
            begin
                cmd.sol_we  = 1'b1;
                cmd.sol_idx = i_reg;
                if (sts.div_done)
                begin
                    if (i_reg == '0)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT_LD;
                    end
                    else
                    begin
                        i_next     = i_reg - IW'(1);
                        state_next = S_BS_I;
                    end
                end
            end
            S_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                cmd.sol_idx  = k_reg;
                cmd.out_last = (k_reg == n_m1);
                state_next   = S_EMIT_W;
            end
            S_EMIT_W:
            begin
                if (!out_stall)
                begin
                    if (k_reg == n_m1)
                    begin
                        i_next     = '0;
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + IW'(1);
                        state_next = S_EMIT_LD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            size_reg  <= SIZE_W'(MAX_N);
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            r_reg     <= '0;
            sing_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            r_reg     <= r_next;
            sing_reg  <= sing_next;
        end
    end

    assign in_stall  = (state_reg != S_LOAD) || cfg_write;
    assign out_valid = (state_reg == S_EMIT_W);

endmodule

// File: hdl/linear_system_solver.sv
// top level of the gaussian elimination solver
// The solver takes an N x (N+1) augmented system [A|b] as signed Q16.16 entries, one
// transaction per cycle in row-major order with the right-hand side last in each row,
// N being the size register (0 reads as 1, above 8 as 8). Loading runs at one entry per
// cycle unless the size register is written; after the last entry the input stalls while
// the block eliminates forward (a row swap only on an exactly zero pivot) and
// back-substitutes, then emits the N solution entries in index order, each with singular
// and last flags. Solve time is set by the one read port of the matrix store and the
// bit-serial divider. A singular system stops elimination early and returns all-zero
// solutions with singular set. Writing the size register during loading restarts it.
module linear_system_solver (
    input  logic                          clk,
    input  logic                          rst_n,
    // size register write port
    input  logic                          cfg_write,
    input  logic [lss_pkg::SIZE_W-1:0]    cfg_data,
    // input transaction: one matrix entry
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [31:0]            value,
    // output transaction: one solution entry
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            solution,
    output logic [lss_pkg::OUT_IDX_W-1:0] index,
    output logic                          singular,
    output logic                          last
);
    import lss_pkg::*;

    lss_cmd_t cmd;
    lss_sts_t sts;

    // sequencer owns the loop counters and the handshakes
    lss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // datapath holds the matrix and all arithmetic
    lss_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .value    (value),
        .solution (solution),
        .index    (index),
        .singular (singular),
        .last     (last)
    );

    // no new entry is taken while results are pending
    a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a result is pending");

    // the final result hands the block back to loading
    a_reload_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && last) |=> !out_valid)
        else $error("results continue past the last entry");

    // a singular system reports zero solutions
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (solution == '0))
        else $error("nonzero solution on a singular system");

endmodule
